// ===== sv/afja_pkg.sv =====
// Shared types and constants for the ASCII frame to joint angle converter.
// No dependencies; used by ascii_frame_to_joint_angles_top.
package afja_pkg;

  localparam int FIELD_DIGITS = 4;
  localparam int FRAME_LEN    = 3 * FIELD_DIGITS + 2;
  localparam int NUM_CH       = 3;

  localparam int COUNT_W = 14;
  localparam int GAIN_W  = 24;
  localparam int ANGLE_W = 15;
  localparam int POS_W   = 4;
  localparam int PROD_W  = COUNT_W + GAIN_W;
  localparam int FRAC_W  = 16;
  localparam int SHIFT_W = PROD_W - FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [GAIN_W-1:0]     gain_t;
  typedef logic [ANGLE_W-1:0]    angle_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [7:0]            byte_t;

  localparam byte_t START_CHAR = 8'h21;
  localparam byte_t END_CHAR   = 8'h24;
  localparam byte_t DIGIT_LO   = 8'h30;
  localparam byte_t DIGIT_HI   = 8'h39;

  localparam pos_t POS_LAST = pos_t'(FRAME_LEN - 1);
  localparam pos_t POS_END  = pos_t'(FRAME_LEN);

  localparam logic [SHIFT_W-1:0] ANGLE_MAX = SHIFT_W'(23040);

  // Configuration register indexes
  localparam cfg_idx_t CFG_OFFSET_CH1 = 3'd0;
  localparam cfg_idx_t CFG_GAIN_CH1   = 3'd1;
  localparam cfg_idx_t CFG_OFFSET_CH2 = 3'd2;
  localparam cfg_idx_t CFG_GAIN_CH2   = 3'd3;
  localparam cfg_idx_t CFG_OFFSET_CH3 = 3'd4;
  localparam cfg_idx_t CFG_GAIN_CH3   = 3'd5;

  localparam count_t OFFSET_CH1_RST = 14'd166;
  localparam gain_t  GAIN_CH1_RST   = 24'd10207450;
  localparam count_t OFFSET_CH2_RST = 14'd183;
  localparam gain_t  GAIN_CH2_RST   = 24'd9994700;
  localparam count_t OFFSET_CH3_RST = 14'd188;
  localparam gain_t  GAIN_CH3_RST   = 24'd10278600;

endpackage

// ===== sv/ascii_frame_to_joint_angles_top.sv =====
// ASCII frame to joint angle converter, top level.
// Depends on afja_pkg for types, register indexes and frame constants.
//
// The block takes one received byte per transfer on the in_ channel and
// parses fixed 14-byte frames of the form '!', three 4-character decimal
// fields, '$'. Each field accumulates digits from the left and stops at
// the first non-digit; a field opening with a non-digit reads 0. There is
// no resynchronisation: a new frame always starts 14 bytes after the last.
// When the closing byte is taken, one result transfer follows on the out_
// channel carrying frame_ok and three angles in units of 1/256 degree,
// each ((count - offset) * gain) >> 16 clamped to 0..23040; a bad frame
// gives zero angles. A byte may be taken in every cycle. A result reaches
// out_ from its closing byte through the capture stage, one multiplier
// per channel, then shift and clamp into the output register; each stage
// holds its contents while the stage after it is full and cannot load, so
// in_stall rises only once the capture stage is backed up by a stalled
// output. Offsets and gains are written through the cfg_ port (index 0..5
// in the order offset_ch1, gain_ch1, offset_ch2, gain_ch2, offset_ch3,
// gain_ch3); cfg_ready is always high and writes should only be made while
// no frame is in flight.
module ascii_frame_to_joint_angles_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  afja_pkg::byte_t             in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_frame_ok,
  output afja_pkg::angle_t            out_angle_one,
  output afja_pkg::angle_t            out_angle_two,
  output afja_pkg::angle_t            out_angle_three,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  afja_pkg::cfg_idx_t          cfg_index,
  input  afja_pkg::cfg_data_t         cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  afja_pkg::count_t offset_r [afja_pkg::NUM_CH];
  afja_pkg::gain_t  gain_r   [afja_pkg::NUM_CH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r[0] <= afja_pkg::OFFSET_CH1_RST;
      gain_r[0]   <= afja_pkg::GAIN_CH1_RST;
      offset_r[1] <= afja_pkg::OFFSET_CH2_RST;
      gain_r[1]   <= afja_pkg::GAIN_CH2_RST;
      offset_r[2] <= afja_pkg::OFFSET_CH3_RST;
      gain_r[2]   <= afja_pkg::GAIN_CH3_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afja_pkg::CFG_OFFSET_CH1: offset_r[0] <= cfg_data[afja_pkg::COUNT_W-1:0];
        afja_pkg::CFG_GAIN_CH1:   gain_r[0]   <= cfg_data[afja_pkg::GAIN_W-1:0];
        afja_pkg::CFG_OFFSET_CH2: offset_r[1] <= cfg_data[afja_pkg::COUNT_W-1:0];
        afja_pkg::CFG_GAIN_CH2:   gain_r[1]   <= cfg_data[afja_pkg::GAIN_W-1:0];
        afja_pkg::CFG_OFFSET_CH3: offset_r[2] <= cfg_data[afja_pkg::COUNT_W-1:0];
        afja_pkg::CFG_GAIN_CH3:   gain_r[2]   <= cfg_data[afja_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage may load when it is empty or when the
  // stage after it is loading too.
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_load;
  logic s2_load;
  logic s1_free;
  logic in_take;

  assign out_load = !out_valid_r || !out_stall;
  assign s2_load  = !s2_valid_r || out_load;
  assign s1_free  = !s1_valid_r || s2_load;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Frame parser
  // ---------------------------------------------------------------------
  afja_pkg::pos_t   pos_r, pos_nxt;
  logic             start_seen_r, start_seen_nxt;
  logic             stopped_r, stopped_nxt;
  afja_pkg::count_t field_r [afja_pkg::NUM_CH];
  afja_pkg::count_t field_nxt [afja_pkg::NUM_CH];

  afja_pkg::pos_t   pos_eff;
  afja_pkg::pos_t   rel;
  afja_pkg::pos_t   fsel_wide;
  logic [1:0]       fsel;
  logic             field_first;
  logic             is_digit;
  afja_pkg::count_t acc_base;
  afja_pkg::count_t acc_new;
  logic             frame_end;
  logic             frame_ok;

  always_comb begin
    pos_eff     = (pos_r >= afja_pkg::POS_END) ? '0 : pos_r;
    rel         = pos_eff - afja_pkg::pos_t'(1);
    fsel_wide   = afja_pkg::pos_t'(rel / afja_pkg::FIELD_DIGITS);
    fsel        = (fsel_wide > afja_pkg::pos_t'(2)) ? 2'd2 : fsel_wide[1:0];
    field_first = (rel % afja_pkg::FIELD_DIGITS) == 0;
    is_digit    = (in_rx_byte >= afja_pkg::DIGIT_LO) && (in_rx_byte <= afja_pkg::DIGIT_HI);
    acc_base    = field_first ? '0 : field_r[fsel];
    acc_new     = (acc_base << 3) + (acc_base << 1)
                + afja_pkg::count_t'(in_rx_byte - afja_pkg::DIGIT_LO);
    frame_end   = (pos_eff == afja_pkg::POS_LAST);
    frame_ok    = start_seen_r && (in_rx_byte == afja_pkg::END_CHAR);

    pos_nxt        = pos_r;
    start_seen_nxt = start_seen_r;
    stopped_nxt    = stopped_r;
    field_nxt      = field_r;

    if (in_take) begin
      if (pos_eff == '0) begin
        start_seen_nxt = (in_rx_byte == afja_pkg::START_CHAR);
        pos_nxt        = afja_pkg::pos_t'(1);
      end else if (!frame_end) begin
        // A field's first character clears the stop flag before testing.
        if ((field_first || !stopped_r) && is_digit) begin
          field_nxt[fsel] = acc_new;
          stopped_nxt     = 1'b0;
        end else begin
          if (field_first) field_nxt[fsel] = '0;
          stopped_nxt = 1'b1;
        end
        pos_nxt = pos_eff + afja_pkg::pos_t'(1);
      end else begin
        pos_nxt        = '0;
        start_seen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      start_seen_r <= 1'b0;
      stopped_r    <= 1'b0;
      for (int i = 0; i < afja_pkg::NUM_CH; i++) field_r[i] <= '0;
    end else begin
      pos_r        <= pos_nxt;
      start_seen_r <= start_seen_nxt;
      stopped_r    <= stopped_nxt;
      field_r      <= field_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: counts of a finished frame.
  // ---------------------------------------------------------------------
  logic             s1_ok_r;
  afja_pkg::count_t s1_count_r [afja_pkg::NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_take && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_take && frame_end) begin
      s1_ok_r    <= frame_ok;
      s1_count_r <= field_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: subtract offset and multiply by gain, one multiplier a channel.
  // ---------------------------------------------------------------------
  logic              s2_ok_r;
  logic              s2_pos_r  [afja_pkg::NUM_CH];
  afja_pkg::prod_t   s2_prod_r [afja_pkg::NUM_CH];
  logic              diff_pos  [afja_pkg::NUM_CH];
  afja_pkg::count_t  diff      [afja_pkg::NUM_CH];

  always_comb begin
    for (int i = 0; i < afja_pkg::NUM_CH; i++) begin
      diff_pos[i] = s1_count_r[i] > offset_r[i];
      diff[i]     = s1_count_r[i] - offset_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_ok_r <= s1_ok_r;
      for (int i = 0; i < afja_pkg::NUM_CH; i++) begin
        s2_pos_r[i]  <= diff_pos[i];
        s2_prod_r[i] <= afja_pkg::prod_t'(diff[i]) * afja_pkg::prod_t'(gain_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: drop the fraction and clamp to 0..90 degrees.
  // ---------------------------------------------------------------------
  logic                                  out_ok_r;
  afja_pkg::angle_t                      out_angle_r [afja_pkg::NUM_CH];
  afja_pkg::angle_t                      angle_nxt   [afja_pkg::NUM_CH];
  logic [afja_pkg::SHIFT_W-1:0]          shifted     [afja_pkg::NUM_CH];

  always_comb begin
    for (int i = 0; i < afja_pkg::NUM_CH; i++) begin
      shifted[i] = s2_prod_r[i][afja_pkg::PROD_W-1:afja_pkg::FRAC_W];
      if (!s2_ok_r || !s2_pos_r[i]) begin
        angle_nxt[i] = '0;
      end else if (shifted[i] > afja_pkg::ANGLE_MAX) begin
        angle_nxt[i] = afja_pkg::ANGLE_MAX[afja_pkg::ANGLE_W-1:0];
      end else begin
        angle_nxt[i] = shifted[i][afja_pkg::ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid_r) begin
      out_ok_r    <= s2_ok_r;
      out_angle_r <= angle_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ok    = out_ok_r;
  assign out_angle_one   = out_angle_r[0];
  assign out_angle_two   = out_angle_r[1];
  assign out_angle_three = out_angle_r[2];

endmodule
